// ===== hdl/spd_pkg.sv =====
// Shared types and constants for the shortest path block.
`default_nettype none
package spd_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int WEIGHT_BITS_DEF  = 16;
   localparam int DIST_BITS_DEF    = 24;
   localparam int PATH_LIMIT       = 16;
   localparam int COUNT_BITS       = 5;
   localparam int PATH_IDX_BITS    = 4;
   localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = 5'd16;

   localparam logic OP_ADD_ARC = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  from_vertex;
      logic [3:0]  to_vertex;
      logic [15:0] arc_duration;
      logic [15:0] arc_cost;
      logic        weight_by_duration;
   } req_type;

   typedef struct packed {
      logic [3:0]  path_vertex;
      logic        path_found;
      logic [23:0] path_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic mark;
      logic relax;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== hdl/spd_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
`default_nettype none
interface spd_chan_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/spd_ram.sv =====
// Generic RAM, one write port, one read port with registered read data.
`default_nettype none
module spd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/spd_cell.sv =====
// One vertex cell: distance, predecessor, resolved flag, and a stage of the min-select chain.
`default_nettype none
module spd_cell #(
   parameter int VERTEX_BITS = 4,
   parameter int DIST_BITS   = 24,
   parameter int CELL_INDEX  = 0
) (
   input  wire logic                          clock,
   input  wire spd_pkg::cell_ctl_type         ctl,
   input  wire logic [VERTEX_BITS-1:0]        origin,
   input  wire logic [VERTEX_BITS-1:0]        cur,
   input  wire logic [VERTEX_BITS-1:0]        target,
   input  wire logic [DIST_BITS-1:0]          cand,
   input  wire logic                          sel_in_valid,
   input  wire logic [VERTEX_BITS-1:0]        sel_in_idx,
   input  wire logic                          sel_in_finite,
   input  wire logic [DIST_BITS-1:0]          sel_in_dist,
   output logic                               sel_out_valid,
   output logic      [VERTEX_BITS-1:0]        sel_out_idx,
   output logic                               sel_out_finite,
   output logic      [DIST_BITS-1:0]          sel_out_dist,
   output logic      [DIST_BITS-1:0]          best,
   output logic                               pred_valid,
   output logic      [VERTEX_BITS-1:0]        pred
);
   import spd_pkg::*;

   localparam logic [VERTEX_BITS-1:0] MY_INDEX = VERTEX_BITS'(CELL_INDEX);

   logic [DIST_BITS-1:0]   best_ff, best_in;
   logic                   inf_ff, inf_in;
   logic                   pv_ff, pv_in;
   logic [VERTEX_BITS-1:0] pred_ff, pred_in;
   logic                   res_ff, res_in;
   logic                   sv_ff, sv_in;
   logic [VERTEX_BITS-1:0] si_ff, si_in;
   logic                   sf_ff, sf_in;
   logic [DIST_BITS-1:0]   sd_ff, sd_in;

   always_comb begin
      best_in = best_ff;
      inf_in  = inf_ff;
      pv_in   = pv_ff;
      pred_in = pred_ff;
      res_in  = res_ff;
      if (ctl.clear) begin
         best_in = '0;
         inf_in  = (origin != MY_INDEX);
         pv_in   = 1'b0;
         pred_in = '0;
         res_in  = 1'b0;
      end else begin
         if (ctl.mark && cur == MY_INDEX) begin
            res_in = 1'b1;
         end
         if (ctl.relax && target == MY_INDEX && (inf_ff || cand < best_ff)) begin
            best_in = cand;
            inf_in  = 1'b0;
            pred_in = cur;
            pv_in   = 1'b1;
         end
      end
   end

   // running minimum handed to the right neighbor
   always_comb begin
      sv_in = sel_in_valid;
      si_in = sel_in_idx;
      sf_in = sel_in_finite;
      sd_in = sel_in_dist;
      if (!res_ff) begin
         if (!sel_in_valid) begin
            sv_in = 1'b1;
            si_in = MY_INDEX;
         end
         if (!inf_ff && (!sel_in_finite || best_ff < sel_in_dist)) begin
            sv_in = 1'b1;
            si_in = MY_INDEX;
            sf_in = 1'b1;
            sd_in = best_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      inf_ff  <= inf_in;
      pv_ff   <= pv_in;
      pred_ff <= pred_in;
      res_ff  <= res_in;
      sv_ff   <= sv_in;
      si_ff   <= si_in;
      sf_ff   <= sf_in;
      sd_ff   <= sd_in;
   end

   assign sel_out_valid  = sv_ff;
   assign sel_out_idx    = si_ff;
   assign sel_out_finite = sf_ff;
   assign sel_out_dist   = sd_ff;
   assign best           = best_ff;
   assign pred_valid     = pv_ff;
   assign pred           = pred_ff;
endmodule
`default_nettype wire

// ===== hdl/shortest_path_dijkstra.sv =====
// Shortest path engine: arc store and dense Dijkstra over a chain of vertex cells.
//
// Input channel req_chan carries add-arc and query items; result channel
// rsp_chan carries path vertices, origin first, the final one marked last.
// An add-arc item gives no result. A query clears the cells in its accept
// cycle, then runs up to n rounds (n = active vertex count): a selection
// wave down the cell chain, then, if the selected vertex is reachable, a
// pass that reads its arcs from the weight RAM and broadcasts each
// candidate distance to its cell. The path walk then follows predecessor
// links back from the destination. A rejected query (bad vertex or
// origin = destination) gives its single not-found result the cycle after
// accept.
// Results are held in place while the receiver stalls; no new item is
// taken until the last result of a query transfers. Configuration is
// written through csr_we/csr_wdata. Synchronous reset clears the arc
// present flags and sets the vertex count to 16; weights are kept in RAM.
`default_nettype none
module shortest_path_dijkstra #(
   parameter int MAX_VERTICES = spd_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = spd_pkg::WEIGHT_BITS_DEF,
   parameter int DIST_BITS    = spd_pkg::DIST_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   spd_chan_if.sink                             req_chan,
   spd_chan_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [spd_pkg::COUNT_BITS-1:0]  csr_wdata
);
   import spd_pkg::*;

   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int AW     = 2 * VW;
   localparam int SLOTS  = 1 << AW;
   localparam int SW     = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam int LIMIT  = (MAX_VERTICES < PATH_LIMIT) ? MAX_VERTICES : PATH_LIMIT;
   localparam logic [COUNT_BITS-1:0] LIMIT_C = COUNT_BITS'(LIMIT);
   localparam logic [SW-1:0] DIST_MAX = SW'({DIST_BITS{1'b1}});

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_RELAX = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   req_type req;
   logic    req_fire, rsp_fire;

   logic [COUNT_BITS-1:0] vc_ff, vc_in, n_act;
   logic [2:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] round_ff, round_in;
   logic [COUNT_BITS-1:0] depth_ff, depth_in;
   logic [VW-1:0]         org_ff, org_in;
   logic [VW-1:0]         dst_ff, dst_in;
   logic [VW-1:0]         cur_ff, cur_in;
   logic [DIST_BITS-1:0]  cdist_ff, cdist_in;
   logic                  bydur_ff, bydur_in;
   logic                  nf_ff, nf_in;
   logic [PATH_IDX_BITS-1:0] eidx_ff, eidx_in;
   logic [23:0]           tot_ff, tot_in;
   logic                  rv_ff, rv_in;
   logic [VW-1:0]         rt_ff, rt_in;
   logic [SLOTS-1:0]      present_ff, present_in;
   logic                  pres_ff, pres_in;
   logic [3:0]            stack_ff [PATH_LIMIT];
   logic [3:0]            stack_in [PATH_LIMIT];

   logic                  add_ok, q_bad;
   logic [VW-1:0]         a_v, b_v;
   logic [AW-1:0]         rd_addr;
   logic [2*WEIGHT_BITS-1:0] wr_data, rd_data;
   logic [WEIGHT_BITS-1:0]   w_sel;
   logic [SW-1:0]         sum;
   logic [DIST_BITS-1:0]  cand;
   cell_ctl_type          ctl;
   logic [VW-1:0]         walk_nxt;
   logic [DIST_BITS+23:0] dst_ext;

   logic                  sv [MAX_VERTICES+1];
   logic [VW-1:0]         si [MAX_VERTICES+1];
   logic                  sf [MAX_VERTICES+1];
   logic [DIST_BITS-1:0]  sd [MAX_VERTICES+1];
   logic [DIST_BITS-1:0]  cdist_w [MAX_VERTICES];
   logic                  pv_w [MAX_VERTICES];
   logic [VW-1:0]         pred_w [MAX_VERTICES];

   assign req      = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      n_act = vc_ff;
      if (n_act == '0) n_act = COUNT_BITS'(1);
      if (n_act > LIMIT_C) n_act = LIMIT_C;
   end

   assign a_v    = VW'(req.from_vertex);
   assign b_v    = VW'(req.to_vertex);
   assign add_ok = ({1'b0, req.from_vertex} < COUNT_BITS'(MAX_VERTICES) || MAX_VERTICES >= 16)
                && ({1'b0, req.to_vertex} < COUNT_BITS'(MAX_VERTICES) || MAX_VERTICES >= 16);
   assign q_bad  = ({1'b0, req.from_vertex} >= n_act) || ({1'b0, req.to_vertex} >= n_act)
                || (req.from_vertex == req.to_vertex);
   assign wr_data = {WEIGHT_BITS'(req.arc_duration), WEIGHT_BITS'(req.arc_cost)};
   assign rd_addr = {cur_ff, VW'(cnt_ff)};

   spd_ram #(.WIDTH(2 * WEIGHT_BITS), .DEPTH(SLOTS)) u_weights (
      .clock   (clock),
      .wr_en   (req_fire && req.opcode == OP_ADD_ARC && add_ok),
      .wr_addr ({a_v, b_v}),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign w_sel = bydur_ff ? rd_data[2*WEIGHT_BITS-1:WEIGHT_BITS] : rd_data[WEIGHT_BITS-1:0];
   assign sum   = SW'(cdist_ff) + SW'(w_sel);
   assign cand  = (sum > DIST_MAX) ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];

   assign sv[0] = 1'b0;
   assign si[0] = '0;
   assign sf[0] = 1'b0;
   assign sd[0] = '0;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      spd_cell #(.VERTEX_BITS(VW), .DIST_BITS(DIST_BITS), .CELL_INDEX(i)) u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .origin         (org_in),
         .cur            (ctl.relax ? cur_ff : cur_in),
         .target         (rt_ff),
         .cand           (cand),
         .sel_in_valid   (sv[i]),
         .sel_in_idx     (si[i]),
         .sel_in_finite  (sf[i]),
         .sel_in_dist    (sd[i]),
         .sel_out_valid  (sv[i+1]),
         .sel_out_idx    (si[i+1]),
         .sel_out_finite (sf[i+1]),
         .sel_out_dist   (sd[i+1]),
         .best           (cdist_w[i]),
         .pred_valid     (pv_w[i]),
         .pred           (pred_w[i])
      );
   end

   assign walk_nxt  = pred_w[cur_ff];
   assign dst_ext   = {24'd0, cdist_w[dst_ff]};

   always_comb begin
      state_in   = state_ff;
      vc_in      = csr_we ? csr_wdata : vc_ff;
      cnt_in     = cnt_ff;
      round_in   = round_ff;
      depth_in   = depth_ff;
      org_in     = org_ff;
      dst_in     = dst_ff;
      cur_in     = cur_ff;
      cdist_in   = cdist_ff;
      bydur_in   = bydur_ff;
      nf_in      = nf_ff;
      eidx_in    = eidx_ff;
      tot_in     = tot_ff;
      rv_in      = 1'b0;
      rt_in      = VW'(cnt_ff);
      pres_in    = present_ff[rd_addr];
      present_in = present_ff;
      stack_in   = stack_ff;
      ctl        = '0;
      ctl.relax  = rv_ff && pres_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.opcode == OP_ADD_ARC) begin
                  if (add_ok) present_in[{a_v, b_v}] = 1'b1;
               end else if (q_bad) begin
                  nf_in    = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  org_in    = a_v;
                  dst_in    = b_v;
                  bydur_in  = req.weight_by_duration;
                  nf_in     = 1'b0;
                  ctl.clear = 1'b1;
                  cnt_in    = '0;
                  round_in  = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + COUNT_BITS'(1);
            if (cnt_ff == n_act) begin
               cnt_in = '0;
               if (!sv[n_act]) begin
                  depth_in = '0;
                  cur_in   = dst_ff;
                  state_in = ST_WALK;
               end else begin
                  cur_in   = si[n_act];
                  cdist_in = sd[n_act];
                  ctl.mark = 1'b1;
                  if (sf[n_act]) begin
                     state_in = ST_RELAX;
                  end else if (round_ff == n_act - COUNT_BITS'(1)) begin
                     depth_in = '0;
                     cur_in   = dst_ff;
                     state_in = ST_WALK;
                  end else begin
                     round_in = round_ff + COUNT_BITS'(1);
                  end
               end
            end
         end
         ST_RELAX: begin
            if (cnt_ff < n_act) begin
               rv_in  = 1'b1;
               cnt_in = cnt_ff + COUNT_BITS'(1);
            end else begin
               cnt_in = '0;
               if (round_ff == n_act - COUNT_BITS'(1)) begin
                  depth_in = '0;
                  cur_in   = dst_ff;
                  state_in = ST_WALK;
               end else begin
                  round_in = round_ff + COUNT_BITS'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_WALK: begin
            tot_in = dst_ext[23:0];
            if (depth_ff < n_act && pv_w[cur_ff]) begin
               stack_in[depth_ff[PATH_IDX_BITS-1:0]] = 4'(cur_ff);
               depth_in = depth_ff + COUNT_BITS'(1);
               cur_in   = walk_nxt;
               if (walk_nxt == org_ff) begin
                  if (depth_ff + COUNT_BITS'(1) >= n_act) begin
                     nf_in = 1'b1;
                  end else begin
                     stack_in[PATH_IDX_BITS'(depth_ff + COUNT_BITS'(1))] = 4'(org_ff);
                     eidx_in = PATH_IDX_BITS'(depth_ff + COUNT_BITS'(1));
                  end
                  state_in = ST_EMIT;
               end
            end else begin
               nf_in    = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (nf_ff || eidx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  eidx_in = eidx_ff - PATH_IDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         vc_ff      <= VERTEX_COUNT_RESET;
         present_ff <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vc_ff      <= vc_in;
         present_ff <= present_in;
         rv_ff      <= rv_in;
      end
      cnt_ff   <= cnt_in;
      round_ff <= round_in;
      depth_ff <= depth_in;
      org_ff   <= org_in;
      dst_ff   <= dst_in;
      cur_ff   <= cur_in;
      cdist_ff <= cdist_in;
      bydur_ff <= bydur_in;
      nf_ff    <= nf_in;
      eidx_ff  <= eidx_in;
      tot_ff   <= tot_in;
      rt_ff    <= rt_in;
      pres_ff  <= pres_in;
      stack_ff <= stack_in;
   end

   assign rsp_chan.valid               = (state_ff == ST_EMIT);
   assign rsp_chan.payload.path_vertex = nf_ff ? 4'd0 : stack_ff[eidx_ff];
   assign rsp_chan.payload.path_found  = ~nf_ff;
   assign rsp_chan.payload.path_total  = nf_ff ? 24'd0 : tot_ff;
   assign rsp_chan.payload.last        = nf_ff || (eidx_ff == '0);
endmodule
`default_nettype wire

// ===== test/shortest_path_dijkstra_test.sv =====
// Testbench for the shortest path engine: arc loads, path queries and scoreboard checks.
`timescale 1ns / 100ps

class path_scoreboard;
   bit                 arc_on[256];
   logic [15:0]        dur_w[256];
   logic [15:0]        cost_w[256];
   logic [4:0]         vcount;
   spd_pkg::rsp_type   pending[$];
   int                 errors;
   int                 queries;
   int                 hops_seen;

   function new();
      vcount = spd_pkg::VERTEX_COUNT_RESET;
      errors = 0;
      queries = 0;
      hops_seen = 0;
   endfunction

   task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   function int active_n();
      if (vcount == 0) return 1;
      if (vcount > 16) return 16;
      return vcount;
   endfunction

   function void push_miss();
      spd_pkg::rsp_type r;
      r.path_vertex = '0;
      r.path_found = 1'b0;
      r.path_total = '0;
      r.last = 1'b1;
      pending.insert(pending.size(), r);
   endfunction

   // note one accepted request and queue the path it yields
   function void note_request(spd_pkg::req_type q);
      int n, a, b, cur, pick, depth, slot;
      bit pick_fin, reached;
      logic [24:0] pick_d, cand;
      logic [24:0] best[16];
      bit inf[16], pv[16], done[16];
      int pred[16], stack[17];
      spd_pkg::rsp_type r;
      a = q.from_vertex;
      b = q.to_vertex;
      if (q.opcode == spd_pkg::OP_ADD_ARC) begin
         slot = a * 16 + b;
         arc_on[slot] = 1'b1;
         dur_w[slot] = q.arc_duration;
         cost_w[slot] = q.arc_cost;
         return;
      end
      queries++;
      n = active_n();
      if (a >= n || b >= n || a == b) begin
         push_miss();
         return;
      end
      for (int v = 0; v < 16; v++) begin
         best[v] = '0;
         inf[v] = 1'b1;
         pv[v] = 1'b0;
         done[v] = 1'b0;
         pred[v] = 0;
      end
      inf[a] = 1'b0;
      for (int rnd = 0; rnd < n; rnd++) begin
         pick = n;
         pick_fin = 1'b0;
         pick_d = '0;
         for (int v = 0; v < n; v++) begin
            if (done[v]) continue;
            if (pick == n) pick = v;
            if (!inf[v] && (!pick_fin || best[v] < pick_d)) begin
               pick = v;
               pick_fin = 1'b1;
               pick_d = best[v];
            end
         end
         if (pick >= n) break;
         done[pick] = 1'b1;
         if (inf[pick]) continue;
         for (int v = 0; v < n; v++) begin
            slot = pick * 16 + v;
            if (!arc_on[slot]) continue;
            cand = best[pick] + (q.weight_by_duration ? dur_w[slot] : cost_w[slot]);
            if (cand > 25'hFFFFFF) cand = 25'hFFFFFF;
            if (inf[v] || cand < best[v]) begin
               best[v] = cand;
               inf[v] = 1'b0;
               pred[v] = pick;
               pv[v] = 1'b1;
            end
         end
      end
      depth = 0;
      cur = b;
      reached = 1'b0;
      while (depth < n && pv[cur]) begin
         stack[depth++] = cur;
         cur = pred[cur];
         if (cur >= n) break;
         if (cur == a) begin
            reached = 1'b1;
            break;
         end
      end
      if (!reached || depth >= n) begin
         push_miss();
         return;
      end
      stack[depth++] = a;
      for (int k = 0; k < depth; k++) begin
         r.path_vertex = 4'(stack[depth - 1 - k]);
         r.path_found = 1'b1;
         r.path_total = best[b][23:0];
         r.last = (k == depth - 1);
         pending.insert(pending.size(), r);
      end
   endfunction

   task check_result(spd_pkg::rsp_type got);
      spd_pkg::rsp_type exp;
      hops_seen++;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result %h", got));
         return;
      end
      exp = pending.pop_front();
      if (got.path_vertex !== exp.path_vertex)
         report($sformatf("path_vertex %0d, want %0d", got.path_vertex, exp.path_vertex));
      if (got.path_found !== exp.path_found)
         report($sformatf("path_found %0d, want %0d", got.path_found, exp.path_found));
      if (got.path_total !== exp.path_total)
         report($sformatf("path_total %0d, want %0d", got.path_total, exp.path_total));
      if (got.last !== exp.last)
         report($sformatf("last %0d, want %0d", got.last, exp.last));
   endtask
endclass

module shortest_path_dijkstra_test;
   import spd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [COUNT_BITS-1:0] csr_wdata = '0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   path_scoreboard sb = new();

   spd_chan_if #(.PAYLOAD_TYPE(req_type)) req_chan();
   spd_chan_if #(.PAYLOAD_TYPE(rsp_type)) rsp_chan();

   shortest_path_dijkstra u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) sb.note_request(req_chan.payload);
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.payload);
   end

   task automatic send_item(req_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_BITS-1:0] value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      sb.vcount = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_arc(int f, int t, int d, int c);
      req_type it;
      it = '0;
      it.opcode = OP_ADD_ARC;
      it.from_vertex = 4'(f);
      it.to_vertex = 4'(t);
      it.arc_duration = 16'(d);
      it.arc_cost = 16'(c);
      it.weight_by_duration = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic req_type make_query(int f, int t, bit by_dur);
      req_type it;
      it.opcode = OP_QUERY;
      it.from_vertex = 4'(f);
      it.to_vertex = 4'(t);
      it.arc_duration = 16'($urandom);
      it.arc_cost = 16'($urandom);
      it.weight_by_duration = by_dur;
      return it;
   endfunction

   function automatic int pick_vertex(int n);
      if ($urandom_range(99) < 12) return $urandom_range(15);
      return $urandom_range(n - 1);
   endfunction

   function automatic int pick_weight();
      case ($urandom_range(9))
         0: return 0;
         1: return 16'hFFFF;
         2: return $urandom_range(16'hFFFF);
         default: return $urandom_range(1, 60);
      endcase
   endfunction

   task automatic random_items(int count);
      int n;
      for (int i = 0; i < count; i++) begin
         n = sb.active_n();
         if (i == count / 2) drain();
         if ($urandom_range(99) < 55)
            send_item(make_arc(pick_vertex(n), pick_vertex(n), pick_weight(), pick_weight()));
         else
            send_item(make_query(pick_vertex(n), pick_vertex(n), $urandom_range(1)));
      end
   endtask

   initial begin
      int counts[6];
      int stall_modes[4][2];
      counts = '{16, 1, 0, 31, 6, 0};
      stall_modes = '{'{0, 0}, '{64, 0}, '{0, 64}, '{31, 31}};
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: chain 0->1->2 vs direct 0->2, extremes, self arc, overwrite
      write_count(5'd16);
      send_item(make_query(0, 5, 1'b0));
      send_item(make_arc(0, 1, 0, 16'hFFFF));
      send_item(make_arc(1, 2, 0, 16'hFFFF));
      send_item(make_arc(0, 2, 5, 1));
      send_item(make_query(0, 2, 1'b1));
      send_item(make_query(0, 2, 1'b0));
      send_item(make_query(3, 3, 1'b1));
      send_item(make_query(2, 0, 1'b1));
      send_item(make_arc(15, 15, 7, 7));
      send_item(make_arc(2, 15, 16'hFFFF, 16'hFFFF));
      send_item(make_arc(14, 15, 3, 3));
      send_item(make_query(0, 15, 1'b1));
      send_item(make_query(0, 15, 1'b0));
      send_item(make_arc(0, 2, 0, 0));
      send_item(make_query(0, 15, 1'b0));
      send_item(make_arc(0, 3, 1, 1));
      send_item(make_arc(3, 2, 0, 0));
      send_item(make_query(0, 2, 1'b0));
      write_count(5'd3);
      send_item(make_query(0, 15, 1'b1));
      send_item(make_query(0, 2, 1'b1));
      send_item(make_query(3, 0, 1'b1));

      counts[5] = $urandom_range(2, 16);
      for (int s = 0; s < 6; s++) begin
         write_count(COUNT_BITS'(counts[s]));
         send_idle_pct = stall_modes[s % 4][0];
         recv_stall_pct = stall_modes[s % 4][1];
         random_items(60);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      $display("ran %0d queries, %0d path results, vertex counts 0 to 31, four idle mixes",
               sb.queries, sb.hops_seen);
      if (sb.errors == 0)
         $display("shortest_path_dijkstra_test: clean");
      else
         $display("shortest_path_dijkstra_test: errors");
      $finish;
   end

   initial begin
      #40ms;
      $display("shortest_path_dijkstra_test: errors");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/spd_pkg.sv
hdl/spd_chan_if.sv
hdl/spd_ram.sv
hdl/spd_cell.sv
hdl/shortest_path_dijkstra.sv
test/shortest_path_dijkstra_test.sv
